// ===== hw/rtl/rcl_pkg.sv =====
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the RGB 3x3 convolution line buffer.
// ----------------------------------------------------------------------------
package rcl_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } out_item_t;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_DIV   = 3'd2;
  localparam logic [2:0] REG_KERNEL_TOP   = 3'd3;
  localparam logic [2:0] REG_KERNEL_MID   = 3'd4;
  localparam logic [2:0] REG_KERNEL_BOT   = 3'd5;

  localparam int unsigned SUM_W = 19;  // magnitude of a non-negative channel sum
  localparam logic [7:0] PIX_MAX = 8'd255;

endpackage

// ===== hw/rtl/rgb_conv3x3_line_buffer.sv =====
// ----------------------------------------------------------------------------
// rgb_conv3x3_line_buffer
// 3x3 RGB convolution over a three-line store, border pixels clamped.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  in        input      in_valid_i / in_ready_o         rcl_pkg::in_item_t
//  out       output     out_valid_o / out_ready_i       rcl_pkg::out_item_t
//  config    input      psel/penable/pwrite, pready=1   6 registers at 4*i
//
//  An item without a result is accepted and evaluated, and the next item
//  can follow; an item with a result also passes through nine window reads
//  through the single store read port and the last accumulate, a divider
//  start, 19 steps of the shared three-channel divider and a wait to see it
//  finish, and the output register load before the next item is taken.
//  Reset clears control state only; the store is not cleared.
//  A finished result waits in the output register while a new item is taken;
//  the next result stalls only if that register is still full.
// ----------------------------------------------------------------------------
module rgb_conv3x3_line_buffer #(
  parameter int unsigned LINE_DEPTH = 1920
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rcl_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rcl_pkg::out_item_t   out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AddrW = $clog2(3 * LINE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_READ, ST_DSTART, ST_DWAIT, ST_OUT
  } state_e;

  // configuration
  logic [10:0] fw_q;
  logic [11:0] fh_q;
  logic [15:0] kdiv_q;
  logic [23:0] ktop_q, kmid_q, kbot_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // positions
  logic [11:0] in_row_q, out_row_q;
  logic [10:0] in_col_q, out_col_q;
  logic [1:0]  in_slot_q, out_slot_q;

  // item
  state_e      state_q;
  logic        act_q;
  logic [23:0] pix_q;
  logic        have_pix_q;
  logic [11:0] rr_q;
  logic [10:0] rc_q;
  logic        adv_row_q;

  // window walk
  logic [1:0]  ti_q, tj_q;
  logic [3:0]  tap_q;
  logic        acc_v_q;
  logic        fwd_q;
  logic signed [7:0] coef_q;
  logic signed [19:0] sum_q [3];

  logic                out_valid_q;
  rcl_pkg::out_item_t  out_q;

  // effective sizes
  logic [12:0] fw_ext, wmin;
  logic [10:0] w_c;
  logic [11:0] h_c;

  // evaluation
  logic        have_pix_c;
  logic [12:0] rr_c, rc_c, need_r, need_c;
  logic        rdy_c;

  // tap addressing
  logic [11:0] sr;
  logic [10:0] sc;
  logic [1:0]  sslot;
  logic [23:0] krow;
  logic [AddrW-1:0] raddr, waddr;
  logic        mem_re, mem_we;
  logic [23:0] rdata;
  logic [23:0] px;
  logic signed [16:0] prod [3];

  logic        last_c;
  logic        div_start, div_done;
  logic [2:0][rcl_pkg::SUM_W-1:0] div_num;
  logic [2:0]  div_neg;
  logic [2:0][7:0] div_quo;

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [AddrW-1:0] slot_base(input logic [1:0] s);
    logic [AddrW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AddrW'(LINE_DEPTH);
      default: b = AddrW'(2 * LINE_DEPTH);
    endcase
    return b;
  endfunction

  assign fw_ext = {2'b00, fw_q};
  assign wmin   = (fw_ext > 13'(LINE_DEPTH)) ? 13'(LINE_DEPTH) : fw_ext;
  assign w_c    = (fw_q == 11'd0) ? 11'd1 : wmin[10:0];
  assign h_c    = (fh_q == 12'd0) ? 12'd1 : fh_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      rcl_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, fw_q};
      rcl_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, fh_q};
      rcl_pkg::REG_KERNEL_DIV:   prdata = {16'd0, kdiv_q};
      rcl_pkg::REG_KERNEL_TOP:   prdata = {8'd0, ktop_q};
      rcl_pkg::REG_KERNEL_MID:   prdata = {8'd0, kmid_q};
      rcl_pkg::REG_KERNEL_BOT:   prdata = {8'd0, kbot_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // item evaluation
  always_comb begin
    have_pix_c = (act_q == rcl_pkg::ACT_PIXEL) && (in_row_q < h_c);
    rr_c = {1'b0, in_row_q};
    rc_c = {2'b00, in_col_q};
    if (have_pix_c) begin
      rc_c = {2'b00, in_col_q} + 13'd1;
      if (rc_c >= {2'b00, w_c}) begin
        rc_c = '0;
        rr_c = {1'b0, in_row_q} + 13'd1;
      end
    end
    need_r = ({1'b0, out_row_q} + 13'd1 < {1'b0, h_c}) ? {1'b0, out_row_q} + 13'd1
                                                      : {1'b0, h_c} - 13'd1;
    need_c = ({2'b00, out_col_q} + 13'd1 < {2'b00, w_c}) ? {2'b00, out_col_q} + 13'd1
                                                        : {2'b00, w_c} - 13'd1;
    rdy_c = (out_row_q < h_c) && ((need_r < rr_c) || (need_r == rr_c && need_c < rc_c));
  end

  // window tap source position
  always_comb begin
    case (ti_q)
      2'd0: begin
        sr    = (out_row_q == 12'd0) ? 12'd0 : out_row_q - 12'd1;
        sslot = (out_row_q == 12'd0) ? out_slot_q : slot_inc(slot_inc(out_slot_q));
        krow  = ktop_q;
      end
      2'd1: begin
        sr    = out_row_q;
        sslot = out_slot_q;
        krow  = kmid_q;
      end
      default: begin
        sr    = (out_row_q == h_c - 12'd1) ? out_row_q : out_row_q + 12'd1;
        sslot = (out_row_q == h_c - 12'd1) ? out_slot_q : slot_inc(out_slot_q);
        krow  = kbot_q;
      end
    endcase
    case (tj_q)
      2'd0:    sc = (out_col_q == 11'd0) ? 11'd0 : out_col_q - 11'd1;
      2'd1:    sc = out_col_q;
      default: sc = (out_col_q == w_c - 11'd1) ? out_col_q : out_col_q + 11'd1;
    endcase
  end

  assign raddr  = slot_base(sslot) + AddrW'(sc);
  assign waddr  = slot_base(in_slot_q) + AddrW'(in_col_q);
  assign mem_re = (state_q == ST_READ) && (tap_q < 4'd9);
  assign last_c = (out_row_q == h_c - 12'd1) && (out_col_q == w_c - 11'd1);
  assign mem_we = ((state_q == ST_EVAL) && !rdy_c && have_pix_c) ||
                  ((state_q == ST_OUT) && have_pix_q && (!out_valid_q || out_ready_i));

  rcl_line_store #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(waddr),
    .wdata_i(pix_q),
    .re_i   (mem_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign px = fwd_q ? pix_q : rdata;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = $signed({1'b0, px[8*c +: 8]}) * coef_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div_neg[c] = sum_q[c][19];
      div_num[c] = sum_q[c][rcl_pkg::SUM_W-1:0];
    end
  end

  assign div_start = (state_q == ST_DSTART);

  rcl_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .neg_i  (div_neg),
    .den_i  (kdiv_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= 11'd1920;
      fh_q        <= 12'd1080;
      kdiv_q      <= 16'd1;
      ktop_q      <= 24'h000000;
      kmid_q      <= 24'h010000;
      kbot_q      <= 24'h000000;
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      in_slot_q   <= '0;
      out_slot_q  <= '0;
      state_q     <= ST_IDLE;
      have_pix_q  <= 1'b0;
      acc_v_q     <= 1'b0;
      tap_q       <= '0;
      ti_q        <= '0;
      tj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_wr) begin
        case (cfg_idx)
          rcl_pkg::REG_FRAME_WIDTH: begin
            fw_q <= pwdata[10:0];
            in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
            in_slot_q <= '0; out_slot_q <= '0;
          end
          rcl_pkg::REG_FRAME_HEIGHT: begin
            fh_q <= pwdata[11:0];
            in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
            in_slot_q <= '0; out_slot_q <= '0;
          end
          rcl_pkg::REG_KERNEL_DIV: kdiv_q <= pwdata[15:0];
          rcl_pkg::REG_KERNEL_TOP: ktop_q <= pwdata[23:0];
          rcl_pkg::REG_KERNEL_MID: kmid_q <= pwdata[23:0];
          rcl_pkg::REG_KERNEL_BOT: kbot_q <= pwdata[23:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          have_pix_q <= have_pix_c;
          rr_q       <= rr_c[11:0];
          rc_q       <= rc_c[10:0];
          adv_row_q  <= rr_c[11:0] != in_row_q;
          if (rdy_c) begin
            tap_q   <= '0;
            ti_q    <= '0;
            tj_q    <= '0;
            acc_v_q <= 1'b0;
            state_q <= ST_READ;
          end else begin
            // no result: commit the pixel now
            if (have_pix_c) begin
              in_row_q <= rr_c[11:0];
              in_col_q <= rc_c[10:0];
              if (rr_c[11:0] != in_row_q) begin
                in_slot_q <= slot_inc(in_slot_q);
              end
            end
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          acc_v_q <= mem_re;
          if (mem_re) begin
            tap_q <= tap_q + 4'd1;
            if (tj_q == 2'd2) begin
              tj_q <= 2'd0;
              ti_q <= ti_q + 2'd1;
            end else begin
              tj_q <= tj_q + 2'd1;
            end
          end else begin
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            if (last_c) begin
              in_row_q <= '0; in_col_q <= '0; out_row_q <= '0; out_col_q <= '0;
              in_slot_q <= '0; out_slot_q <= '0;
            end else begin
              if (have_pix_q) begin
                in_row_q <= rr_q;
                in_col_q <= rc_q;
                if (adv_row_q) begin
                  in_slot_q <= slot_inc(in_slot_q);
                end
              end
              if (out_col_q + 11'd1 >= w_c) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + 12'd1;
                out_slot_q <= slot_inc(out_slot_q);
              end else begin
                out_col_q <= out_col_q + 11'd1;
              end
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      act_q <= in_data_i.action;
      pix_q <= {in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in};
    end
    if (state_q == ST_EVAL) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= '0;
      end
    end
    if (mem_re) begin
      // take the incoming pixel where the tap hits the not-yet-written spot
      fwd_q  <= have_pix_q && (sr == in_row_q) && (sc == in_col_q);
      coef_q <= $signed(krow[8*tj_q +: 8]);
    end
    if (state_q == ST_READ && acc_v_q) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sum_q[c] + {{3{prod[c][16]}}, prod[c]};
      end
    end
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.red_out   <= div_quo[0];
      out_q.green_out <= div_quo[1];
      out_q.blue_out  <= div_quo[2];
      out_q.frame_end <= last_c;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("store read and write in the same cycle");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DWAIT))
    else $error("divider finished outside its wait state");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("result not loaded into output register");
`endif

endmodule

// ===== hw/rtl/rcl_line_store.sv =====
// ----------------------------------------------------------------------------
// rcl_line_store
// Three-line pixel store, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module rcl_line_store #(
  parameter int unsigned LINE_DEPTH = 1920
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(3*LINE_DEPTH)-1:0]   waddr_i,
  input  logic [23:0]                       wdata_i,
  input  logic                              re_i,
  input  logic [$clog2(3*LINE_DEPTH)-1:0]   raddr_i,
  output logic [23:0]                       rdata_o
);

  localparam int unsigned Depth = 3 * LINE_DEPTH;

  logic [23:0] mem_q [Depth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rcl_divider.sv =====
// ----------------------------------------------------------------------------
// rcl_divider
// Three-channel restoring divider, one quotient bit per cycle, clamps to a pixel.
// ----------------------------------------------------------------------------
module rcl_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [2:0][rcl_pkg::SUM_W-1:0]      num_i,
  input  logic [2:0]                          neg_i,
  input  logic [15:0]                         den_i,
  output logic                                done_o,
  output logic [2:0][7:0]                     quo_o
);

  localparam int unsigned SumW = rcl_pkg::SUM_W;

  logic                      busy_q;
  logic [4:0]                cnt_q;
  logic                      done_q;
  logic [15:0]               den_q;
  logic [2:0]                neg_q;
  logic [2:0][SumW-1:0]      nq_q;   // numerator shifts out, quotient shifts in
  logic [2:0][16:0]          rem_q;
  logic [2:0][16:0]          rem_sh;
  logic [2:0]                ge;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem_q[c][15:0], nq_q[c][SumW-1]};
      ge[c]     = rem_sh[c] >= {1'b0, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 5'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= (den_i == 16'd0) ? 16'd1 : den_i;
      neg_q <= neg_i;
      nq_q  <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= ge[c] ? (rem_sh[c] - {1'b0, den_q}) : rem_sh[c];
        nq_q[c]  <= {nq_q[c][SumW-2:0], ge[c]};
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (neg_q[c]) begin
        quo_o[c] = 8'd0;
      end else if (nq_q[c] > SumW'(rcl_pkg::PIX_MAX)) begin
        quo_o[c] = rcl_pkg::PIX_MAX;
      end else begin
        quo_o[c] = nq_q[c][7:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== tb/rgb_conv3x3_line_buffer_test.sv =====
// ----------------------------------------------------------------------------
// rgb_conv3x3_line_buffer_test
// Streams raster RGB frames of many sizes and kernels into the convolution
// line buffer and compares each filtered pixel with a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_conv3x3_line_buffer_test;

  localparam int unsigned LINE_DEPTH = 1920;
  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TARGET_ITEMS = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  rcl_pkg::in_item_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rcl_pkg::out_item_t out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rgb_conv3x3_line_buffer #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [23:0] pix_mem [3*LINE_DEPTH];
  logic [10:0] cfg_width = 11'd1920;
  logic [11:0] cfg_height = 12'd1080;
  logic [15:0] cfg_div = 16'd1;
  logic [23:0] cfg_krow [3] = '{24'h0, 24'h010000, 24'h0};
  int unsigned rd_row, rd_col, wr_row, wr_col;

  rcl_pkg::in_item_t  pixel_queue [$];
  rcl_pkg::out_item_t filtered_expect [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        send_pause = 1'b0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_frames = 0;
  int unsigned quiet_cycles = 0;

  function automatic void filter_pixel(rcl_pkg::in_item_t it);
    int unsigned w, h, rr, rc, need_r, need_c, sr, sc, d;
    int          sum [3];
    int          q, k;
    logic [23:0] px, pix;
    logic        have, fire;
    rcl_pkg::out_item_t res;
    w = (cfg_width == 0) ? 1 : cfg_width;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    h = (cfg_height == 0) ? 1 : cfg_height;
    pix = {it.blue_in, it.green_in, it.red_in};
    have = (it.action == rcl_pkg::ACT_PIXEL) && (rd_row < h);
    rr = rd_row;
    rc = rd_col;
    if (have) begin
      rc = rd_col + 1;
      if (rc >= w) begin
        rc = 0;
        rr = rd_row + 1;
      end
    end
    need_r = (wr_row + 1 < h) ? wr_row + 1 : h - 1;
    need_c = (wr_col + 1 < w) ? wr_col + 1 : w - 1;
    fire = (wr_row < h) && (need_r < rr || (need_r == rr && need_c < rc));
    if (fire) begin
      sum = '{0, 0, 0};
      d = (cfg_div == 0) ? 1 : cfg_div;
      for (int i = 0; i < 3; i++) begin
        sr = (int'(wr_row) + i - 1 < 0) ? 0 :
             (wr_row + i - 1 >= h) ? h - 1 : wr_row + i - 1;
        for (int j = 0; j < 3; j++) begin
          sc = (int'(wr_col) + j - 1 < 0) ? 0 :
               (wr_col + j - 1 >= w) ? w - 1 : wr_col + j - 1;
          k = $signed(cfg_krow[i][8*j +: 8]);
          // the incoming pixel may complete its own window
          px = (have && sr == rd_row && sc == rd_col) ? pix
               : pix_mem[(sr % 3) * LINE_DEPTH + sc];
          for (int c = 0; c < 3; c++) sum[c] += int'(px[8*c +: 8]) * k;
        end
      end
      for (int c = 0; c < 3; c++) begin
        q = sum[c] / int'(d);
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        sum[c] = q;
      end
      res.red_out   = sum[0][7:0];
      res.green_out = sum[1][7:0];
      res.blue_out  = sum[2][7:0];
      res.frame_end = (wr_row == h - 1 && wr_col == w - 1);
      filtered_expect.push_back(res);
    end
    if (have) begin
      pix_mem[(rd_row % 3) * LINE_DEPTH + rd_col] = pix;
      rd_row = rr;
      rd_col = rc;
    end
    if (fire) begin
      if (wr_row == h - 1 && wr_col == w - 1) begin
        rd_row = 0; rd_col = 0; wr_row = 0; wr_col = 0;
        n_frames++;
      end else if (wr_col + 1 >= w) begin
        wr_col = 0;
        wr_row++;
      end else begin
        wr_col++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_mismatch++;
  endtask

  // Driver: accept, predict, then offer the next item or hold the current one
  always @(posedge clk_i) begin
    logic offer;
    if (in_valid_i && in_ready_o) begin
      filter_pixel(in_data_i);
      n_in++;
    end
    if (!(in_valid_i && !in_ready_o)) begin
      offer = rst_ni && pixel_queue.size() != 0 && !send_pause &&
              $urandom_range(99) >= send_idle_pct;
      in_valid_i <= offer;
      if (offer) in_data_i <= pixel_queue.pop_front();
    end
  end

  // Receiver ready with its own long hold-off counter
  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    out_ready_i <= rst_ni && !hold_start && hold_left <= 1 &&
                   $urandom_range(99) >= recv_stall_pct;
  end

  // Monitor
  always @(posedge clk_i) begin
    rcl_pkg::out_item_t want;
    if (out_valid_o && out_ready_i) begin
      n_out++;
      if (filtered_expect.size() == 0) begin
        report_mismatch("unexpected item, frame_end", out_data_o.frame_end, 0);
      end else begin
        want = filtered_expect.pop_front();
        if (out_data_o.red_out !== want.red_out)
          report_mismatch("red_out", out_data_o.red_out, want.red_out);
        if (out_data_o.green_out !== want.green_out)
          report_mismatch("green_out", out_data_o.green_out, want.green_out);
        if (out_data_o.blue_out !== want.blue_out)
          report_mismatch("blue_out", out_data_o.blue_out, want.blue_out);
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", out_data_o.frame_end, want.frame_end);
      end
    end
  end

  // Watchdog on cycles without any handshake or register access
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("rgb_conv3x3_line_buffer: mismatch");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_valid_i || filtered_expect.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rcl_pkg::REG_FRAME_WIDTH:  cfg_width = val[10:0];
      rcl_pkg::REG_FRAME_HEIGHT: cfg_height = val[11:0];
      rcl_pkg::REG_KERNEL_DIV:   cfg_div = val[15:0];
      rcl_pkg::REG_KERNEL_TOP:   cfg_krow[0] = val[23:0];
      rcl_pkg::REG_KERNEL_MID:   cfg_krow[1] = val[23:0];
      rcl_pkg::REG_KERNEL_BOT:   cfg_krow[2] = val[23:0];
      default: ;
    endcase
    if (idx == rcl_pkg::REG_FRAME_WIDTH || idx == rcl_pkg::REG_FRAME_HEIGHT) begin
      rd_row = 0; rd_col = 0; wr_row = 0; wr_col = 0;
    end
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned dv,
                       logic [23:0] kt, logic [23:0] km, logic [23:0] kb);
    wait_idle();
    reg_write(rcl_pkg::REG_FRAME_WIDTH, w);
    reg_write(rcl_pkg::REG_FRAME_HEIGHT, h);
    reg_write(rcl_pkg::REG_KERNEL_DIV, dv);
    reg_write(rcl_pkg::REG_KERNEL_TOP, kt);
    reg_write(rcl_pkg::REG_KERNEL_MID, km);
    reg_write(rcl_pkg::REG_KERNEL_BOT, kb);
  endtask

  task automatic push_item(logic act, logic [23:0] rgb);
    rcl_pkg::in_item_t it;
    it.action = act;
    {it.blue_in, it.green_in, it.red_in} = rgb;
    pixel_queue.push_back(it);
  endtask

  // Queue npix pixels (drains sprinkled in at noise_pct), then enough drains
  task automatic push_frame(int unsigned npix, int unsigned w, int unsigned noise_pct);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise_pct) push_item(rcl_pkg::ACT_DRAIN, 24'($urandom));
      push_item(rcl_pkg::ACT_PIXEL, 24'($urandom));
    end
    for (int unsigned i = 0; i < w + 2; i++) push_item(rcl_pkg::ACT_DRAIN, 24'($urandom));
  endtask

  function automatic logic [23:0] rand_kernel();
    case ($urandom_range(3))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {$urandom_range(0, 4) == 0 ? 8'h80 : 8'($urandom_range(0, 6)),
                 8'($urandom_range(0, 6)), 8'h7F};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned w, h, dv, mode;
    logic did_hold, did_pause;
    did_hold = 1'b0;
    did_pause = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: early drain, extreme pixels, surplus pixels, extreme kernels
    setup(4, 3, 0, 24'h7F8001, 24'h00FF80, 24'h807F7F);
    push_item(rcl_pkg::ACT_DRAIN, 24'hFFFFFF);
    for (int i = 0; i < 12; i++)
      push_item(rcl_pkg::ACT_PIXEL, (i % 2) ? 24'hFFFFFF : 24'h000000);
    push_item(rcl_pkg::ACT_PIXEL, 24'hABCDEF);
    push_item(rcl_pkg::ACT_PIXEL, 24'h123456);
    for (int i = 0; i < 6; i++) push_item(rcl_pkg::ACT_DRAIN, 24'h0);
    // zero size acts as one pixel frames
    setup(0, 0, 1, 24'h0, 24'h010000, 24'h0);
    push_item(rcl_pkg::ACT_PIXEL, 24'h00FF00);
    push_item(rcl_pkg::ACT_PIXEL, 24'hFF00FF);
    // size change abandons a partial frame
    setup(3, 3, 65535, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    push_frame(4, 0, 0);
    setup(5, 2, 9, 24'h010101, 24'h010101, 24'h010101);
    push_frame(10, 5, 0);
    // tallest frame, partially streamed
    setup(1, 4095, 2, 24'h000100, 24'h000200, 24'h000100);
    push_frame(8, 1, 0);
    // widest rows, clamped to the line depth, partially streamed
    setup(2047, 2, 1, 24'h000001, 24'h010001, 24'h000100);
    push_frame(16, 2, 0);

    // Random frames rotating through idle modes
    mode = 0;
    while (n_in < TARGET_ITEMS) begin
      w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(3))
        0: dv = 0;
        1: dv = 1;
        2: dv = $urandom_range(2, 16);
        default: dv = $urandom_range(0, 65535);
      endcase
      setup(w, h, dv, rand_kernel(), rand_kernel(), rand_kernel());
      @(posedge clk_i);
      send_idle_pct  <= (mode == 3) ? 7 : (mode == 1) ? 80 : 0;
      recv_stall_pct <= (mode == 3) ? 7 : (mode == 2) ? 80 : 0;
      mode = (mode + 1) % 4;
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        // some frames are cut short
        push_frame(($urandom_range(7) == 0) ? $urandom_range(1, 8)
                   : ((w ? w : 1) * (h ? h : 1)), w ? w : 1, 10);
        if (!did_pause && n_in > TARGET_ITEMS / 2) begin
          // hold the sender until every pending result has drained
          did_pause = 1'b1;
          @(posedge clk_i) send_pause <= 1'b1;
          while (filtered_expect.size() != 0) @(posedge clk_i);
          @(posedge clk_i) send_pause <= 1'b0;
        end
      end
      if (!did_hold && n_in > TARGET_ITEMS / 3) begin
        // receiver holds off while the sender keeps offering
        did_hold = 1'b1;
        @(posedge clk_i) hold_start <= 1'b1;
        @(posedge clk_i) hold_start <= 1'b0;
      end
    end

    wait_idle();
    $display("streamed %0d items, checked %0d filtered pixels, %0d complete frames",
             n_in, n_out, n_frames);
    if (n_mismatch == 0 && filtered_expect.size() == 0) begin
      $display("rgb_conv3x3_line_buffer: match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch,
               filtered_expect.size());
      $display("rgb_conv3x3_line_buffer: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rcl_pkg.sv
hw/rtl/rcl_line_store.sv
hw/rtl/rcl_divider.sv
hw/rtl/rgb_conv3x3_line_buffer.sv
tb/rgb_conv3x3_line_buffer_test.sv
